>>> src/sctok_pkg.sv
// Shared types, codes and constants for the source code tokenizer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package sctok_pkg;

   // Widths of positions and of the channel fields
   localparam int LINE_BITS   = 16;
   localparam int COLUMN_BITS = 16;
   localparam int CHAR_BITS   = 21;
   localparam int FIELD_BITS  = 16;

   localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
   localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
   localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);
   localparam logic [COLUMN_BITS-1:0] COL_MAX  = {COLUMN_BITS{1'b1}};

   // Token queue between the lexer and the output stage
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Token kinds
   localparam logic [3:0] KIND_EOF     = 4'd0;
   localparam logic [3:0] KIND_NEWLINE = 4'd1;
   localparam logic [3:0] KIND_NAME    = 4'd2;
   localparam logic [3:0] KIND_NUMBER  = 4'd3;
   localparam logic [3:0] KIND_LET     = 4'd4;
   localparam logic [3:0] KIND_RETURN  = 4'd5;
   localparam logic [3:0] KIND_LBRACE  = 4'd6;
   localparam logic [3:0] KIND_RBRACE  = 4'd7;
   localparam logic [3:0] KIND_LPAREN  = 4'd8;
   localparam logic [3:0] KIND_RPAREN  = 4'd9;
   localparam logic [3:0] KIND_COLON   = 4'd10;
   localparam logic [3:0] KIND_SEMI    = 4'd11;
   localparam logic [3:0] KIND_EQUALS  = 4'd12;
   localparam logic [3:0] KIND_ERROR   = 4'd13;

   // Number bases
   localparam logic [1:0] BASE_DEC = 2'd0;
   localparam logic [1:0] BASE_BIN = 2'd1;
   localparam logic [1:0] BASE_OCT = 2'd2;
   localparam logic [1:0] BASE_HEX = 2'd3;

   // Suffix codes
   localparam logic [3:0] SUF_NONE = 4'd0;
   localparam logic [3:0] SUF_I8   = 4'd1;
   localparam logic [3:0] SUF_I16  = 4'd2;
   localparam logic [3:0] SUF_I32  = 4'd3;
   localparam logic [3:0] SUF_I64  = 4'd4;
   localparam logic [3:0] SUF_U8   = 4'd5;
   localparam logic [3:0] SUF_U16  = 4'd6;
   localparam logic [3:0] SUF_U32  = 4'd7;
   localparam logic [3:0] SUF_U64  = 4'd8;
   localparam logic [3:0] SUF_I    = 4'd9;
   localparam logic [3:0] SUF_F32  = 4'd10;
   localparam logic [3:0] SUF_F64  = 4'd11;

   // Error codes
   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
   localparam logic [2:0] ERR_BAD_BASE   = 3'd2;
   localparam logic [2:0] ERR_BAD_FLOAT  = 3'd3;
   localparam logic [2:0] ERR_BAD_INT    = 3'd4;

   // Pack three 7-bit characters, first character in the low bits
   function automatic logic [20:0] pk3(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
      return {c[6:0], b[6:0], a[6:0]};
   endfunction

   localparam logic [20:0] SFX_F32 = pk3("f", "3", "2");
   localparam logic [20:0] SFX_F64 = pk3("f", "6", "4");
   localparam logic [20:0] SFX_I   = pk3("i", 8'd0, 8'd0);
   localparam logic [20:0] SFX_I8  = pk3("i", "8", 8'd0);
   localparam logic [20:0] SFX_I16 = pk3("i", "1", "6");
   localparam logic [20:0] SFX_I32 = pk3("i", "3", "2");
   localparam logic [20:0] SFX_I64 = pk3("i", "6", "4");
   localparam logic [20:0] SFX_U8  = pk3("u", "8", 8'd0);
   localparam logic [20:0] SFX_U16 = pk3("u", "1", "6");
   localparam logic [20:0] SFX_U32 = pk3("u", "3", "2");
   localparam logic [20:0] SFX_U64 = pk3("u", "6", "4");

   localparam logic [41:0] KW_LET    = {21'd0, pk3("l", "e", "t")};
   localparam logic [41:0] KW_RETURN = {pk3("u", "r", "n"), pk3("r", "e", "t")};

   // One result token as it travels to the output
   typedef struct packed {
      logic [3:0]            kind;
      logic [FIELD_BITS-1:0] line;
      logic [FIELD_BITS-1:0] column;
      logic [FIELD_BITS-1:0] length;
      logic [1:0]            base;
      logic                  is_float;
      logic [3:0]            suffix;
      logic [2:0]            err;
      logic [CHAR_BITS-1:0]  bad;
      logic                  last;
   } tok_type;

   // Tokens caused by one input beat: one or two
   typedef struct packed {
      logic    two;
      tok_type first;
      tok_type second;
   } tok_pair_type;

   // Clamp a position to the 16-bit output field
   function automatic logic [FIELD_BITS-1:0] sat16(input logic [31:0] v);
      return (v > 32'd65535) ? 16'hFFFF : v[FIELD_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

>>> src/sctok_req_if.sv
// Input channel of the tokenizer: one code point per beat.
// Depends on sctok_pkg for field widths.
`default_nettype none

interface sctok_req_if;
   import sctok_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CHAR_BITS-1:0] code_point;
   logic                 inside_parens;

   modport source (output valid, output code_point, output inside_parens, input ready);
   modport sink   (input valid, input code_point, input inside_parens, output ready);
endinterface

`default_nettype wire

>>> src/sctok_rsp_if.sv
// Result channel of the tokenizer: one token per beat.
// Depends on sctok_pkg for field widths.
`default_nettype none

interface sctok_rsp_if;
   import sctok_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [3:0]            token_kind;
   logic [FIELD_BITS-1:0] token_line;
   logic [FIELD_BITS-1:0] token_column;
   logic [FIELD_BITS-1:0] value_length;
   logic [1:0]            number_base;
   logic                  number_is_float;
   logic [3:0]            suffix_code;
   logic [2:0]            error_code;
   logic [CHAR_BITS-1:0]  bad_char;
   logic                  last_result;

   modport source (output valid, output token_kind, output token_line, output token_column,
                   output value_length, output number_base, output number_is_float,
                   output suffix_code, output error_code, output bad_char,
                   output last_result, input ready);
   modport sink   (input valid, input token_kind, input token_line, input token_column,
                   input value_length, input number_base, input number_is_float,
                   input suffix_code, input error_code, input bad_char,
                   input last_result, output ready);
endinterface

`default_nettype wire

>>> src/sctok_front.sv
// Lexer front end: accepts code points, runs the character state machine and
// pushes the one or two tokens of each beat. Depends on sctok_pkg, sctok_req_if.
`default_nettype none

module sctok_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   sctok_req_if.sink                   req_if,
   input  wire logic                   q_full,
   output      logic                   push,
   output      sctok_pkg::tok_pair_type push_data
);
   import sctok_pkg::*;

   typedef enum logic [8:0] {
      MODE_IDLE    = 9'b000000001,
      MODE_SKIP    = 9'b000000010,
      MODE_COMMENT = 9'b000000100,
      MODE_IDENT   = 9'b000001000,
      MODE_ZERO    = 9'b000010000,
      MODE_DOT     = 9'b000100000,
      MODE_INT     = 9'b001000000,
      MODE_FRAC    = 9'b010000000,
      MODE_SUFFIX  = 9'b100000000
   } mode_type;

   mode_type               mode_ff, mode_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [COLUMN_BITS-1:0] tstart_ff, tstart_in;
   logic [FIELD_BITS-1:0]  count_ff, count_in;
   logic [1:0]             base_ff, base_in;
   logic                   float_ff, float_in;
   logic [41:0]            kwp_ff, kwp_in;
   logic [20:0]            sufc_ff, sufc_in;
   logic [2:0]             sufn_ff, sufn_in;
   logic [COLUMN_BITS-1:0] sstart_ff, sstart_in;

   logic [CHAR_BITS-1:0]   c;
   logic                   accept;
   logic                   is_nul, is_digit, is_alpha, is_alnum, is_word, base_digit;
   logic [3:0]             punct;
   logic [COLUMN_BITS-1:0] col_next;
   logic [LINE_BITS-1:0]   line_next;
   logic [FIELD_BITS-1:0]  count_sat;
   logic [FIELD_BITS-1:0]  line_out;

   logic                   fin_err;
   logic [2:0]             fin_code;
   logic [COLUMN_BITS-1:0] fin_col;
   logic [3:0]             fin_suf;
   logic                   fin_float;

   logic                   tok_a_v, tok_b_v;
   tok_type                tok_a, tok_b;
   logic                   do_start, do_finish, do_sfx;
   logic                   err_any;

   // Build one token record
   function automatic tok_type make_tok(input logic [3:0] kind,
                                        input logic [FIELD_BITS-1:0] line,
                                        input logic [COLUMN_BITS-1:0] col,
                                        input logic [FIELD_BITS-1:0] len,
                                        input logic [1:0] base, input logic flt,
                                        input logic [3:0] suf, input logic [2:0] err,
                                        input logic [CHAR_BITS-1:0] bad);
      tok_type t;
      t.kind     = kind;
      t.line     = line;
      t.column   = sat16(32'(col));
      t.length   = len;
      t.base     = base;
      t.is_float = flt;
      t.suffix   = suf;
      t.err      = err;
      t.bad      = bad;
      t.last     = 1'b0;
      return t;
   endfunction

   assign c            = req_if.code_point;
   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && !q_full;

   // Classify the character
   always_comb begin
      is_nul   = (c == '0);
      is_digit = (c >= 21'("0")) && (c <= 21'("9"));
      is_alpha = ((c >= 21'("a")) && (c <= 21'("z"))) || ((c >= 21'("A")) && (c <= 21'("Z")));
      is_alnum = is_digit || is_alpha;
      is_word  = is_alnum || (c == 21'("_"));
      unique case (base_ff)
         BASE_BIN: base_digit = (c == 21'("0")) || (c == 21'("1"));
         BASE_OCT: base_digit = (c >= 21'("0")) && (c <= 21'("7"));
         BASE_HEX: base_digit = is_digit || ((c >= 21'("a")) && (c <= 21'("f")))
                                || ((c >= 21'("A")) && (c <= 21'("F")));
         default:  base_digit = is_digit;
      endcase
      priority if (c == 21'("{")) punct = KIND_LBRACE;
      else if (c == 21'("}")) punct = KIND_RBRACE;
      else if (c == 21'("(")) punct = KIND_LPAREN;
      else if (c == 21'(")")) punct = KIND_RPAREN;
      else if (c == 21'(":")) punct = KIND_COLON;
      else if (c == 21'(";")) punct = KIND_SEMI;
      else if (c == 21'("=")) punct = KIND_EQUALS;
      else punct = KIND_EOF;
   end

   assign col_next  = (col_ff != COL_MAX) ? col_ff + COL_ONE : col_ff;
   assign line_next = (line_ff != LINE_MAX) ? line_ff + LINE_ONE : line_ff;
   assign count_sat = (count_ff != 16'hFFFF) ? count_ff + 16'd1 : count_ff;
   assign line_out  = sat16(32'(line_ff));

   // Check the number suffix held so far
   always_comb begin
      fin_err   = 1'b0;
      fin_code  = ERR_NONE;
      fin_col   = sstart_ff;
      fin_suf   = SUF_NONE;
      fin_float = float_ff;
      if (sufn_ff == 3'd0) begin
         fin_suf = SUF_NONE;
      end else if (sufn_ff == 3'd3 && (sufc_ff == SFX_F32 || sufc_ff == SFX_F64)) begin
         if (base_ff != BASE_DEC) begin
            fin_err  = 1'b1;
            fin_code = ERR_BAD_BASE;
            fin_col  = tstart_ff;
         end else begin
            fin_float = 1'b1;
            fin_suf   = (sufc_ff == SFX_F32) ? SUF_F32 : SUF_F64;
         end
      end else if (float_ff) begin
         fin_err  = 1'b1;
         fin_code = ERR_BAD_FLOAT;
      end else begin
         priority if (sufn_ff == 3'd1 && sufc_ff == SFX_I) fin_suf = SUF_I;
         else if (sufn_ff == 3'd2 && sufc_ff == SFX_I8)  fin_suf = SUF_I8;
         else if (sufn_ff == 3'd3 && sufc_ff == SFX_I16) fin_suf = SUF_I16;
         else if (sufn_ff == 3'd3 && sufc_ff == SFX_I32) fin_suf = SUF_I32;
         else if (sufn_ff == 3'd3 && sufc_ff == SFX_I64) fin_suf = SUF_I64;
         else if (sufn_ff == 3'd2 && sufc_ff == SFX_U8)  fin_suf = SUF_U8;
         else if (sufn_ff == 3'd3 && sufc_ff == SFX_U16) fin_suf = SUF_U16;
         else if (sufn_ff == 3'd3 && sufc_ff == SFX_U32) fin_suf = SUF_U32;
         else if (sufn_ff == 3'd3 && sufc_ff == SFX_U64) fin_suf = SUF_U64;
         else begin
            fin_err  = 1'b1;
            fin_code = ERR_BAD_INT;
         end
      end
   end

   // Character state machine: next state and the tokens of this beat
   always_comb begin
      mode_in   = mode_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      tstart_in = tstart_ff;
      count_in  = count_ff;
      base_in   = base_ff;
      float_in  = float_ff;
      kwp_in    = kwp_ff;
      sufc_in   = sufc_ff;
      sufn_in   = sufn_ff;
      sstart_in = sstart_ff;
      tok_a_v   = 1'b0;
      tok_b_v   = 1'b0;
      tok_a     = '0;
      tok_b     = '0;
      do_start  = 1'b0;
      do_finish = 1'b0;
      do_sfx    = 1'b0;

      unique case (mode_ff)
         MODE_SKIP: begin
            if (is_nul) mode_in = MODE_IDLE;
         end
         MODE_COMMENT: begin
            if (is_nul || c == 21'(8'd10)) do_start = 1'b1;
            else col_in = col_next;
         end
         MODE_IDENT: begin
            if (is_word) begin
               for (int i = 1; i < 6; i++) begin
                  if (count_ff == 16'(i)) kwp_in[7*i +: 7] = c[6:0];
               end
               count_in = count_sat;
               col_in   = col_next;
            end else begin
               tok_a_v = 1'b1;
               priority if (count_ff == 16'd3 && kwp_ff == KW_LET)
                  tok_a = make_tok(KIND_LET, line_out, tstart_ff, '0, BASE_DEC, 1'b0,
                                   SUF_NONE, ERR_NONE, '0);
               else if (count_ff == 16'd6 && kwp_ff == KW_RETURN)
                  tok_a = make_tok(KIND_RETURN, line_out, tstart_ff, '0, BASE_DEC, 1'b0,
                                   SUF_NONE, ERR_NONE, '0);
               else
                  tok_a = make_tok(KIND_NAME, line_out, tstart_ff, count_ff, BASE_DEC, 1'b0,
                                   SUF_NONE, ERR_NONE, '0);
               do_start = 1'b1;
            end
         end
         MODE_ZERO, MODE_INT: begin
            if (mode_ff == MODE_ZERO && (c == 21'("b") || c == 21'("o") || c == 21'("x"))) begin
               base_in  = (c == 21'("b")) ? BASE_BIN : (c == 21'("o")) ? BASE_OCT : BASE_HEX;
               count_in = '0;
               mode_in  = MODE_INT;
               col_in   = col_next;
            end else begin
               mode_in = MODE_INT;
               priority if (base_digit) begin
                  count_in = count_sat;
                  col_in   = col_next;
               end else if (base_ff == BASE_DEC && c == 21'(".")) begin
                  float_in = 1'b1;
                  count_in = count_sat;
                  mode_in  = MODE_FRAC;
                  col_in   = col_next;
               end else begin
                  do_sfx = 1'b1;
               end
            end
         end
         MODE_DOT: begin
            if (is_digit) begin
               base_in  = BASE_DEC;
               float_in = 1'b1;
               count_in = 16'd2;
               sufn_in  = '0;
               sufc_in  = '0;
               mode_in  = MODE_FRAC;
               col_in   = col_next;
            end else begin
               tok_a_v = 1'b1;
               tok_a   = make_tok(KIND_ERROR, line_out, tstart_ff, '0, BASE_DEC, 1'b0,
                                  SUF_NONE, ERR_UNEXPECTED, 21'("."));
               line_in = LINE_ONE;
               col_in  = COL_ONE;
               mode_in = is_nul ? MODE_IDLE : MODE_SKIP;
            end
         end
         MODE_FRAC: begin
            if (is_digit) begin
               count_in = count_sat;
               col_in   = col_next;
            end else begin
               do_sfx = 1'b1;
            end
         end
         MODE_SUFFIX: begin
            if (is_alnum) begin
               for (int i = 1; i < 3; i++) begin
                  if (sufn_ff == 3'(i)) sufc_in[7*i +: 7] = c[6:0];
               end
               if (sufn_ff != 3'd7) sufn_in = sufn_ff + 3'd1;
               col_in = col_next;
            end else begin
               do_finish = 1'b1;
            end
         end
         default: begin
            do_start = 1'b1;
         end
      endcase

      // Open a suffix or close the number
      if (do_sfx) begin
         if (is_alnum) begin
            sstart_in = col_ff;
            sufc_in   = {14'd0, c[6:0]};
            sufn_in   = 3'd1;
            mode_in   = MODE_SUFFIX;
            col_in    = col_next;
         end else begin
            do_finish = 1'b1;
         end
      end

      // Emit the number, or the suffix error on this lookahead character
      if (do_finish) begin
         tok_a_v = 1'b1;
         if (fin_err) begin
            tok_a   = make_tok(KIND_ERROR, line_out, fin_col, '0, BASE_DEC, 1'b0,
                               SUF_NONE, fin_code, '0);
            line_in = LINE_ONE;
            col_in  = COL_ONE;
            mode_in = is_nul ? MODE_IDLE : MODE_SKIP;
         end else begin
            tok_a    = make_tok(KIND_NUMBER, line_out, tstart_ff, count_ff, base_ff,
                                fin_float, fin_suf, ERR_NONE, '0);
            float_in = fin_float;
            do_start = 1'b1;
         end
      end

      // Handle the character as the start of something new
      if (do_start) begin
         mode_in = MODE_IDLE;
         priority if (is_nul) begin
            tok_b_v = 1'b1;
            tok_b   = make_tok(KIND_EOF, line_out, col_ff, '0, BASE_DEC, 1'b0,
                               SUF_NONE, ERR_NONE, '0);
            line_in = LINE_ONE;
            col_in  = COL_ONE;
         end else if (c == 21'(" ")) begin
            col_in = col_next;
         end else if (c == 21'(8'd10)) begin
            tok_b_v = !req_if.inside_parens;
            tok_b   = make_tok(KIND_NEWLINE, line_out, col_ff, '0, BASE_DEC, 1'b0,
                               SUF_NONE, ERR_NONE, '0);
            line_in = line_next;
            col_in  = COL_ONE;
         end else if (c == 21'("#")) begin
            mode_in = MODE_COMMENT;
            col_in  = col_next;
         end else if (is_digit) begin
            tstart_in = col_ff;
            count_in  = 16'd1;
            base_in   = BASE_DEC;
            float_in  = 1'b0;
            sufn_in   = '0;
            sufc_in   = '0;
            mode_in   = (c == 21'("0")) ? MODE_ZERO : MODE_INT;
            col_in    = col_next;
         end else if (is_word) begin
            tstart_in = col_ff;
            count_in  = 16'd1;
            kwp_in    = {35'd0, c[6:0]};
            mode_in   = MODE_IDENT;
            col_in    = col_next;
         end else if (c == 21'(".")) begin
            tstart_in = col_ff;
            mode_in   = MODE_DOT;
            col_in    = col_next;
         end else if (punct != KIND_EOF) begin
            tok_b_v = 1'b1;
            tok_b   = make_tok(punct, line_out, col_ff, '0, BASE_DEC, 1'b0,
                               SUF_NONE, ERR_NONE, '0);
            col_in  = col_next;
         end else begin
            tok_b_v = 1'b1;
            tok_b   = make_tok(KIND_ERROR, line_out, col_ff, '0, BASE_DEC, 1'b0,
                               SUF_NONE, ERR_UNEXPECTED, c);
            line_in = LINE_ONE;
            col_in  = COL_ONE;
            mode_in = MODE_SKIP;
         end
      end
   end

   // Pack the tokens of this beat into one queue entry
   always_comb begin
      push           = accept && (tok_a_v || tok_b_v);
      push_data.two  = tok_a_v && tok_b_v;
      push_data.first  = tok_a_v ? tok_a : tok_b;
      push_data.second = tok_b;
   end

   assign err_any = (tok_a_v && tok_a.kind == KIND_ERROR) || (tok_b_v && tok_b.kind == KIND_ERROR);

   // Advance the lexer state on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         line_ff   <= LINE_ONE;
         col_ff    <= COL_ONE;
         tstart_ff <= COL_ONE;
         count_ff  <= '0;
         base_ff   <= BASE_DEC;
         float_ff  <= 1'b0;
         kwp_ff    <= '0;
         sufc_ff   <= '0;
         sufn_ff   <= '0;
         sstart_ff <= COL_ONE;
      end else if (accept) begin
         mode_ff   <= mode_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         tstart_ff <= tstart_in;
         count_ff  <= count_in;
         base_ff   <= base_in;
         float_ff  <= float_in;
         kwp_ff    <= kwp_in;
         sufc_ff   <= sufc_in;
         sufn_ff   <= sufn_in;
         sstart_ff <= sstart_in;
      end
   end

`ifndef ASSERT_OFF
   a_err_restarts_position: assert property (@(posedge clock) disable iff (reset)
      (accept && err_any) |=> (line_ff == LINE_ONE && col_ff == COL_ONE))
      else $error("position not restarted after an error token");

   a_pair_never_after_error: assert property (@(posedge clock) disable iff (reset)
      (push && push_data.two) |-> (push_data.first.kind != KIND_ERROR))
      else $error("a token follows an error token in the same beat");
`endif

endmodule

`default_nettype wire

>>> src/sctok_queue.sv
// Short token queue between the lexer front end and the output stage.
// Depends on sctok_pkg for the entry type and depth.
`default_nettype none

module sctok_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire sctok_pkg::tok_pair_type push_data,
   output      logic                    full,
   output      logic                    head_valid,
   output      sctok_pkg::tok_pair_type head_data,
   input  wire logic                    pop
);
   import sctok_pkg::*;

   tok_pair_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wptr_ff, wptr_in;
   logic [QPTR_BITS-1:0] rptr_ff, rptr_in;
   logic [QCNT_BITS-1:0] cnt_ff, cnt_in;

   assign full       = (cnt_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = mem_ff[rptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push) wptr_in = (wptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      if (pop)  rptr_in = (rptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_data;
   end

`ifndef ASSERT_OFF
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> (cnt_ff != QCNT_BITS'(QUEUE_DEPTH)))
      else $error("token queue overflow");
`endif

endmodule

`default_nettype wire

>>> src/sctok_back.sv
// Output stage: takes queue entries and hands their tokens out one beat at a
// time through an output register. Depends on sctok_pkg, sctok_rsp_if.
`default_nettype none

module sctok_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    head_valid,
   input  wire sctok_pkg::tok_pair_type head_data,
   output      logic                    pop,
   sctok_rsp_if.source                  rsp_if
);
   import sctok_pkg::*;

   logic    out_valid_ff, out_valid_in;
   tok_type out_tok_ff, out_tok_in;
   logic    slot_ff, slot_in;
   logic    load, is_last;
   tok_type pick;

   // Load the next token when the output register is free or drains
   always_comb begin
      load         = head_valid && (!out_valid_ff || rsp_if.ready);
      pick         = slot_ff ? head_data.second : head_data.first;
      is_last      = slot_ff || !head_data.two;
      pop          = load && is_last;
      out_valid_in = load ? 1'b1 : (rsp_if.ready ? 1'b0 : out_valid_ff);
      slot_in      = load ? !is_last : slot_ff;
      out_tok_in   = out_tok_ff;
      if (load) begin
         out_tok_in      = pick;
         out_tok_in.last = is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         slot_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         slot_ff      <= slot_in;
      end
   end

   // Hold the payload
   always_ff @(posedge clock) begin
      out_tok_ff <= out_tok_in;
   end

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.token_kind      = out_tok_ff.kind;
   assign rsp_if.token_line      = out_tok_ff.line;
   assign rsp_if.token_column    = out_tok_ff.column;
   assign rsp_if.value_length    = out_tok_ff.length;
   assign rsp_if.number_base     = out_tok_ff.base;
   assign rsp_if.number_is_float = out_tok_ff.is_float;
   assign rsp_if.suffix_code     = out_tok_ff.suffix;
   assign rsp_if.error_code      = out_tok_ff.err;
   assign rsp_if.bad_char        = out_tok_ff.bad;
   assign rsp_if.last_result     = out_tok_ff.last;

`ifndef ASSERT_OFF
   a_second_follows_first: assert property (@(posedge clock) disable iff (reset)
      slot_ff |-> (out_valid_ff && !out_tok_ff.last))
      else $error("second token pending without a first token on the output");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from an empty token queue");
`endif

endmodule

`default_nettype wire

>>> src/source_code_tokenizer.sv
// Source code tokenizer, top level: lexer front end, token queue, output stage.
// Usage:
//   req_if carries one Unicode code point per beat plus the parser's
//   inside_parens flag; code point 0 marks end of source. rsp_if carries one
//   token per beat; last_result marks the final token caused by an input beat.
//   A beat gives zero, one or two tokens.
// Path: the tokens of a beat are registered in the token queue, then in the
//   output register; a second token follows the first through that register.
// Throughput: one code point per clock while req_if.ready is high; the single
//   output register delivers one token per clock while rsp_if.ready is high,
//   so two-token beats hold off req_if once the two-entry token queue fills.
// Reset (synchronous): the lexer goes idle between tokens at line 1, column 1,
//   and the queue and the output register empty.
// Stall: while rsp_if.ready is low the current token holds; the queue absorbs
//   up to two more beats' worth of tokens, then req_if.ready drops.
// Depends on sctok_pkg, sctok_req_if, sctok_rsp_if, sctok_front, sctok_queue,
//   sctok_back.
`default_nettype none

module source_code_tokenizer (
   input  wire logic   clock,
   input  wire logic   reset,
   sctok_req_if.sink   req_if,
   sctok_rsp_if.source rsp_if
);
   import sctok_pkg::*;

   logic         q_full;
   logic         push;
   tok_pair_type push_data;
   logic         head_valid;
   tok_pair_type head_data;
   logic         pop;

   sctok_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   sctok_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (q_full),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop)
   );

   sctok_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_if     (rsp_if)
   );

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking bench for source_code_tokenizer: streams code points, predicts tokens.
// Depends on sctok_pkg, sctok_req_if, sctok_rsp_if and the source_code_tokenizer top.
`default_nettype none

module testbench;
   import sctok_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LONG_HOLD      = 300;
   localparam int SETTLE_CYCLES  = 4;

   typedef enum logic [3:0] {
      LX_IDLE, LX_SKIP, LX_COMMENT, LX_IDENT, LX_ZERO, LX_DOT, LX_INT, LX_FRAC, LX_SUFFIX
   } lex_mode_type;

   typedef struct {
      logic [CHAR_BITS-1:0] cp;
      logic                 paren;
   } src_char_type;

   // Tracks lexer state per accepted code point and matches delivered tokens
   class token_scoreboard;
      tok_type     expected_tokens[$];
      int unsigned mismatch_count;
      int unsigned checked_count;

      lex_mode_type             mode;
      logic [LINE_BITS-1:0]     line_no;
      logic [COLUMN_BITS-1:0]   col_no;
      logic [COLUMN_BITS-1:0]   tok_col;
      logic [COLUMN_BITS-1:0]   sfx_col;
      logic [FIELD_BITS-1:0]    char_count;
      logic [1:0]               base;
      logic                     is_float;
      logic [41:0]              kw_chars;
      logic [20:0]              sfx_chars;
      logic [2:0]               sfx_count;
      tok_type                  held;
      bit                       have_held;

      function new();
         mode       = LX_IDLE;
         line_no    = LINE_ONE;
         col_no     = COL_ONE;
         tok_col    = COL_ONE;
         sfx_col    = COL_ONE;
         char_count = '0;
         base       = BASE_DEC;
         is_float   = 1'b0;
         kw_chars   = '0;
         sfx_chars  = '0;
         sfx_count  = '0;
         have_held  = 0;
      endfunction

      function logic [FIELD_BITS-1:0] clamp_field(logic [31:0] v);
         return (v > 32'd65535) ? 16'hFFFF : v[FIELD_BITS-1:0];
      endfunction

      // Hold back the newest token so the last one of a beat can be marked
      function void emit(logic [3:0] kind, logic [COLUMN_BITS-1:0] col,
                         logic [FIELD_BITS-1:0] len, logic [1:0] b, logic f,
                         logic [3:0] suf, logic [2:0] err, logic [CHAR_BITS-1:0] bad);
         tok_type t;
         t.kind     = kind;
         t.line     = clamp_field(32'(line_no));
         t.column   = clamp_field(32'(col));
         t.length   = len;
         t.base     = b;
         t.is_float = f;
         t.suffix   = suf;
         t.err      = err;
         t.bad      = bad;
         t.last     = 1'b0;
         if (have_held) expected_tokens.push_back(held);
         held      = t;
         have_held = 1;
      endfunction

      function void col_step();
         if (col_no != COL_MAX) col_no = col_no + 1'b1;
      endfunction

      function void bump_count();
         if (char_count != 16'hFFFF) char_count = char_count + 1'b1;
      endfunction

      function bit is_digit(logic [CHAR_BITS-1:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function bit is_alpha(logic [CHAR_BITS-1:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function bit is_alnum(logic [CHAR_BITS-1:0] c);
         return is_digit(c) || is_alpha(c);
      endfunction

      function bit is_base_digit(logic [CHAR_BITS-1:0] c);
         case (base)
            BASE_BIN: return c == "0" || c == "1";
            BASE_OCT: return c >= "0" && c <= "7";
            BASE_HEX: return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
            default:  return is_digit(c);
         endcase
      endfunction

      // Non-punctuator characters map to the error kind
      function logic [3:0] punct_kind(logic [CHAR_BITS-1:0] c);
         case (c)
            "{":     return KIND_LBRACE;
            "}":     return KIND_RBRACE;
            "(":     return KIND_LPAREN;
            ")":     return KIND_RPAREN;
            ":":     return KIND_COLON;
            ";":     return KIND_SEMI;
            "=":     return KIND_EQUALS;
            default: return KIND_ERROR;
         endcase
      endfunction

      // Error token, position restart; a NUL seen as lookahead ends the discard at once
      function void raise_error(logic [2:0] code, logic [COLUMN_BITS-1:0] col,
                                logic [CHAR_BITS-1:0] bad, bit lookahead,
                                logic [CHAR_BITS-1:0] c);
         emit(KIND_ERROR, col, '0, BASE_DEC, 1'b0, SUF_NONE, code, bad);
         line_no = LINE_ONE;
         col_no  = COL_ONE;
         mode    = (lookahead && c == 0) ? LX_IDLE : LX_SKIP;
      endfunction

      // Handle a character seen between tokens
      function void begin_char(logic [CHAR_BITS-1:0] c, logic paren);
         logic [3:0] pkind;
         pkind = punct_kind(c);
         mode  = LX_IDLE;
         if (c == 0) begin
            emit(KIND_EOF, col_no, '0, BASE_DEC, 1'b0, SUF_NONE, ERR_NONE, '0);
            line_no = LINE_ONE;
            col_no  = COL_ONE;
         end else if (c == " ") begin
            col_step();
         end else if (c == "\n") begin
            if (!paren) emit(KIND_NEWLINE, col_no, '0, BASE_DEC, 1'b0, SUF_NONE, ERR_NONE, '0);
            if (line_no != LINE_MAX) line_no = line_no + 1'b1;
            col_no = COL_ONE;
         end else if (c == "#") begin
            mode = LX_COMMENT;
            col_step();
         end else if (is_digit(c)) begin
            tok_col    = col_no;
            char_count = 16'd1;
            base       = BASE_DEC;
            is_float   = 1'b0;
            sfx_count  = '0;
            sfx_chars  = '0;
            mode       = (c == "0") ? LX_ZERO : LX_INT;
            col_step();
         end else if (is_alpha(c) || c == "_") begin
            tok_col    = col_no;
            char_count = 16'd1;
            kw_chars   = 42'(c);
            mode       = LX_IDENT;
            col_step();
         end else if (c == ".") begin
            tok_col = col_no;
            mode    = LX_DOT;
            col_step();
         end else if (pkind != KIND_ERROR) begin
            emit(pkind, col_no, '0, BASE_DEC, 1'b0, SUF_NONE, ERR_NONE, '0);
            col_step();
         end else begin
            raise_error(ERR_UNEXPECTED, col_no, c, 0, c);
         end
      endfunction

      // Validate the suffix, emit the number, then treat c as a fresh character; a bad suffix raises an error instead
      function void close_number(logic [CHAR_BITS-1:0] c, logic paren);
         logic [3:0] suf;
         suf = SUF_NONE;
         if (sfx_count != 0) begin
            if (sfx_count == 3 && (sfx_chars == SFX_F32 || sfx_chars == SFX_F64)) begin
               if (base != BASE_DEC) begin
                  raise_error(ERR_BAD_BASE, tok_col, '0, 1, c);
                  return;
               end
               is_float = 1'b1;
               suf      = (sfx_chars == SFX_F32) ? SUF_F32 : SUF_F64;
            end else if (is_float) begin
               raise_error(ERR_BAD_FLOAT, sfx_col, '0, 1, c);
               return;
            end else begin
               if (sfx_count == 1 && sfx_chars == SFX_I)        suf = SUF_I;
               else if (sfx_count == 2 && sfx_chars == SFX_I8)  suf = SUF_I8;
               else if (sfx_count == 2 && sfx_chars == SFX_U8)  suf = SUF_U8;
               else if (sfx_count == 3 && sfx_chars == SFX_I16) suf = SUF_I16;
               else if (sfx_count == 3 && sfx_chars == SFX_I32) suf = SUF_I32;
               else if (sfx_count == 3 && sfx_chars == SFX_I64) suf = SUF_I64;
               else if (sfx_count == 3 && sfx_chars == SFX_U16) suf = SUF_U16;
               else if (sfx_count == 3 && sfx_chars == SFX_U32) suf = SUF_U32;
               else if (sfx_count == 3 && sfx_chars == SFX_U64) suf = SUF_U64;
               else begin
                  raise_error(ERR_BAD_INT, sfx_col, '0, 1, c);
                  return;
               end
            end
         end
         emit(KIND_NUMBER, tok_col, char_count, base, is_float, suf, ERR_NONE, '0);
         begin_char(c, paren);
      endfunction

      function void suffix_or_close(logic [CHAR_BITS-1:0] c, logic paren);
         if (is_alnum(c)) begin
            sfx_col   = col_no;
            sfx_chars = 21'(c);
            sfx_count = 3'd1;
            mode      = LX_SUFFIX;
            col_step();
         end else begin
            close_number(c, paren);
         end
      endfunction

      function void int_char(logic [CHAR_BITS-1:0] c, logic paren);
         if (is_base_digit(c)) begin
            bump_count();
            col_step();
         end else if (base == BASE_DEC && c == ".") begin
            is_float = 1'b1;
            bump_count();
            mode = LX_FRAC;
            col_step();
         end else begin
            suffix_or_close(c, paren);
         end
      endfunction

      // Advance the lexer by one accepted code point and queue its tokens
      function void note_code_point(logic [CHAR_BITS-1:0] c, logic paren);
         case (mode)
            LX_SKIP: begin
               if (c == 0) mode = LX_IDLE;
            end
            LX_COMMENT: begin
               if (c == 0 || c == "\n") begin_char(c, paren);
               else col_step();
            end
            LX_IDENT: begin
               if (is_alnum(c) || c == "_") begin
                  if (char_count < 6) kw_chars = kw_chars | (42'(c) << (7 * char_count));
                  bump_count();
                  col_step();
               end else begin
                  if (char_count == 3 && kw_chars == KW_LET)
                     emit(KIND_LET, tok_col, '0, BASE_DEC, 1'b0, SUF_NONE, ERR_NONE, '0);
                  else if (char_count == 6 && kw_chars == KW_RETURN)
                     emit(KIND_RETURN, tok_col, '0, BASE_DEC, 1'b0, SUF_NONE, ERR_NONE, '0);
                  else
                     emit(KIND_NAME, tok_col, char_count, BASE_DEC, 1'b0, SUF_NONE,
                          ERR_NONE, '0);
                  begin_char(c, paren);
               end
            end
            LX_ZERO: begin
               if (c == "b" || c == "o" || c == "x") begin
                  base       = (c == "b") ? BASE_BIN : (c == "o") ? BASE_OCT : BASE_HEX;
                  char_count = '0;
                  mode       = LX_INT;
                  col_step();
               end else begin
                  // the leading zero was a plain decimal digit
                  mode = LX_INT;
                  int_char(c, paren);
               end
            end
            LX_INT: int_char(c, paren);
            LX_DOT: begin
               if (is_digit(c)) begin
                  base       = BASE_DEC;
                  is_float   = 1'b1;
                  char_count = 16'd2;
                  sfx_count  = '0;
                  sfx_chars  = '0;
                  mode       = LX_FRAC;
                  col_step();
               end else begin
                  raise_error(ERR_UNEXPECTED, tok_col, ".", 1, c);
               end
            end
            LX_FRAC: begin
               if (is_digit(c)) begin
                  bump_count();
                  col_step();
               end else begin
                  suffix_or_close(c, paren);
               end
            end
            LX_SUFFIX: begin
               if (is_alnum(c)) begin
                  if (sfx_count < 3) sfx_chars = sfx_chars | (21'(c) << (7 * sfx_count));
                  if (sfx_count < 7) sfx_count = sfx_count + 1'b1;
                  col_step();
               end else begin
                  close_number(c, paren);
               end
            end
            default: begin_char(c, paren);
         endcase
         // mark the final token of this beat
         if (have_held) begin
            held.last = 1'b1;
            expected_tokens.push_back(held);
            have_held = 0;
         end
      endfunction

      function string describe(tok_type t);
         return $sformatf({"kind %0d line %0d col %0d len %0d base %0d float %0b ",
                           "suffix %0d err %0d bad 0x%0h last %0b"},
                          t.kind, t.line, t.column, t.length, t.base, t.is_float,
                          t.suffix, t.err, t.bad, t.last);
      endfunction

      function void check_token(tok_type got);
         tok_type want;
         checked_count++;
         if (expected_tokens.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: token with nothing outstanding: %s", describe(got));
            return;
         end
         want = expected_tokens.pop_front();
         if (got.kind !== want.kind || got.line !== want.line || got.column !== want.column ||
             got.length !== want.length || got.base !== want.base ||
             got.is_float !== want.is_float || got.suffix !== want.suffix ||
             got.err !== want.err || got.bad !== want.bad || got.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: token %0d mismatch\n   expected %s\n   actual   %s",
                        checked_count, describe(want), describe(got));
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   sctok_req_if req_ch();
   sctok_rsp_if rsp_ch();

   source_code_tokenizer uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   token_scoreboard sb;
   src_char_type    text_stream[$];
   bit              send_idle_on;
   bit              rsp_idle_on;
   int              hold_requests;
   int unsigned     items_sent;
   int unsigned     cycle_count;
   int unsigned     quiet_cycles;

   string suffix_pool[17] = '{"i8", "i16", "i32", "i64", "u8", "u16", "u32", "u64", "i",
                              "f32", "f64", "u", "i7", "u128", "f16", "q", "x64z"};
   string punct_pool = "{}():;=";
   string noise_pool = "+-*/!@$%^&,<>?[]~|";

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Receiver: random stall bursts, plus a long hold-off on request
   initial begin : receiver
      int hold_seen;
      int hold_left;
      int burst_left;
      hold_seen    = 0;
      hold_left    = 0;
      burst_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else if (burst_left > 0) begin
            rsp_ch.ready = 1'b0;
            burst_left--;
         end else if (rsp_idle_on && $urandom_range(0, 99) < 15) begin
            rsp_ch.ready = 1'b0;
            burst_left   = $urandom_range(1, 9) - 1;
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   // Sample both channels on the rising edge; input beats are noted before results
   always @(posedge clock) begin : monitor
      tok_type got;
      bit      moved;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         moved = 0;
         cycle_count++;
         if (req_ch.valid && req_ch.ready) begin
            sb.note_code_point(req_ch.code_point, req_ch.inside_parens);
            items_sent++;
            moved = 1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.kind     = rsp_ch.token_kind;
            got.line     = rsp_ch.token_line;
            got.column   = rsp_ch.token_column;
            got.length   = rsp_ch.value_length;
            got.base     = rsp_ch.number_base;
            got.is_float = rsp_ch.number_is_float;
            got.suffix   = rsp_ch.suffix_code;
            got.err      = rsp_ch.error_code;
            got.bad      = rsp_ch.bad_char;
            got.last     = rsp_ch.last_result;
            sb.check_token(got);
            moved = 1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles, %0d tokens outstanding",
                     quiet_cycles, sb.expected_tokens.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // paren_sel 0 or 1 fixes inside_parens, anything else picks it at random
   function automatic void put_char(int cp, int paren_sel = 2);
      src_char_type s;
      s.cp    = CHAR_BITS'(cp);
      s.paren = (paren_sel == 0 || paren_sel == 1) ? paren_sel[0] : 1'($urandom_range(0, 1));
      text_stream.push_back(s);
   endfunction

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) put_char(CHAR_BITS'(s[i]));
   endfunction

   function automatic logic [7:0] ident_char(bit lead);
      int r;
      r = $urandom_range(0, lead ? 52 : 62);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r == 52) return "_";
      return 8'("0" + r - 53);
   endfunction

   function automatic logic [7:0] base_char(int b);
      int r;
      case (b)
         1: return 8'("0" + $urandom_range(0, 1));
         2: return 8'("0" + $urandom_range(0, 7));
         3: begin
            r = $urandom_range(0, 21);
            if (r < 10) return 8'("0" + r);
            if (r < 16) return 8'("a" + r - 10);
            return 8'("A" + r - 16);
         end
         default: return 8'("0" + $urandom_range(0, 9));
      endcase
   endfunction

   function automatic void add_name();
      if ($urandom_range(0, 5) == 0) begin
         put_text($urandom_range(0, 1) ? "let" : "return");
      end else begin
         put_char(ident_char(1));
         repeat ($urandom_range(0, 7)) put_char(ident_char(0));
      end
   endfunction

   // Decimal, float, prefixed or dot-led number, sometimes with a suffix
   function automatic void add_number();
      int shape;
      shape = $urandom_range(0, 9);
      if (shape < 5) begin
         repeat ($urandom_range(1, 5)) put_char(base_char(0));
         if ($urandom_range(0, 9) < 4) begin
            put_char(".");
            repeat ($urandom_range(0, 3)) put_char(base_char(0));
         end
      end else if (shape < 8) begin
         put_char("0");
         put_char(shape == 5 ? "b" : shape == 6 ? "o" : "x");
         repeat ($urandom_range(0, 5)) put_char(base_char(shape - 4));
      end else if (shape == 8) begin
         put_char(".");
         if ($urandom_range(0, 9) == 0) put_char(ident_char(1));
         else repeat ($urandom_range(1, 3)) put_char(base_char(0));
      end else begin
         put_char("0");
      end
      if ($urandom_range(0, 9) < 4) put_text(suffix_pool[$urandom_range(0, 16)]);
   endfunction

   function automatic void add_separator();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) put_char(" ");
      else if (r < 6) put_char(CHAR_BITS'(punct_pool[$urandom_range(0, 6)]));
   endfunction

   function automatic void add_fragment();
      int r;
      int k;
      r = $urandom_range(0, 99);
      if (r < 24) begin
         add_name();
         add_separator();
      end else if (r < 50) begin
         add_number();
         add_separator();
      end else if (r < 62) begin
         put_char(CHAR_BITS'(punct_pool[$urandom_range(0, 6)]));
      end else if (r < 70) begin
         repeat ($urandom_range(1, 3)) put_char(" ");
      end else if (r < 78) begin
         put_char("\n");
      end else if (r < 83) begin
         put_char("#");
         repeat ($urandom_range(0, 8))
            put_char($urandom_range(0, 9) == 0 ? $urandom_range(128, 21'h10FFFF)
                                               : $urandom_range(32, 126));
      end else if (r < 88) begin
         put_char(0);
      end else if (r < 91) begin
         // stray character, usually closed off by a NUL
         k = $urandom_range(0, 3);
         if (k == 0) put_char($urandom_range(1, 21'h10FFFF));
         else if (k == 1) put_char($urandom_range(128, 255));
         else if (k == 2) put_char($urandom_range(1, 31));
         else put_char(CHAR_BITS'(noise_pool[$urandom_range(0, noise_pool.len() - 1)]));
         if ($urandom_range(0, 9) < 6) put_char(0);
      end else begin
         // a whole statement
         put_text("let ");
         add_name();
         put_text(" = ");
         add_number();
         put_char(";");
         put_char("\n");
      end
   endfunction

   function automatic void build_random(int count);
      text_stream.delete();
      while (text_stream.size() < count) add_fragment();
   endfunction

   task automatic send_stream();
      @(negedge clock);
      foreach (text_stream[i]) begin
         if (send_idle_on && $urandom_range(0, 99) < 15) begin
            req_ch.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
         end
         req_ch.valid         = 1'b1;
         req_ch.code_point    = text_stream[i].cp;
         req_ch.inside_parens = text_stream[i].paren;
         do @(posedge clock); while (!req_ch.ready);
         @(negedge clock);
      end
      req_ch.valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.expected_tokens.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      sb                   = new();
      reset                = 1'b1;
      req_ch.valid         = 1'b0;
      req_ch.code_point    = '0;
      req_ch.inside_parens = 1'b0;
      send_idle_on         = 1;
      rsp_idle_on          = 1;
      hold_requests        = 0;
      items_sent           = 0;
      cycle_count          = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty hex number, keyword with paren, newline in parens,
      // bad float suffix then discard, dot error ended by NUL, character above
      // 127, over-long suffix ended by NUL, comment then newline, end of file
      text_stream.delete();
      put_text("0x;let(");
      put_char("\n", 1);
      put_text("9.5u8)");
      put_char(21'h10FFFF);
      put_char(0);
      put_char(".");
      put_char(0);
      put_char(21'h10FFFF);
      put_char(0);
      put_text("7i649");
      put_char(0);
      put_char("#");
      put_char("\n", 0);
      put_char(0);
      send_stream();
      wait_drained();

      // Random token streams with varied idling; first chunk starts with a long stall
      for (int chunk = 0; chunk < 6; chunk++) begin
         send_idle_on = (chunk != 2 && chunk != 3);
         rsp_idle_on  = (chunk != 1 && chunk != 3);
         if (chunk == 0) hold_requests++;
         build_random(150);
         send_stream();
         wait_drained();
      end

      // Closing stretch at full rate
      send_idle_on = 0;
      rsp_idle_on  = 0;
      build_random(450);
      send_stream();
      wait_drained();

      $display("Run: %0d code points in %0d cycles, %0d tokens checked, %0d mismatches",
               items_sent, cycle_count, sb.checked_count, sb.mismatch_count);
      $display("Run: directed corner cases, random token streams, long receiver stall");
      if (sb.mismatch_count == 0 && sb.expected_tokens.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
